// ===== rtl/arw_pkg.sv =====
// shared constants, types and codes of the anti-replay window
`default_nettype none
package arw_pkg;

    localparam int WINDOW_SIZE = 256;
    localparam int WIN_W       = $clog2(WINDOW_SIZE);
    localparam int SEQ_W       = 32;
    localparam int DIGEST_W    = 64;
    localparam int ROW_W       = 4 * DIGEST_W;
    localparam int VERDICT_W   = 2;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_FRESH     = 2'd0,
        VERDICT_DUPLICATE = 2'd1,
        VERDICT_TOO_OLD   = 2'd2,
        VERDICT_CONFLICT  = 2'd3
    } verdict_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EVAL = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/arw_pkt_if.sv =====
// packet item channel: sequence number and digest words
`default_nettype none
interface arw_pkt_if
    import arw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SEQ_W-1:0]    sequence_req;
    logic [DIGEST_W-1:0] digest_w0;
    logic [DIGEST_W-1:0] digest_w1;
    logic [DIGEST_W-1:0] digest_w2;
    logic [DIGEST_W-1:0] digest_w3;

    modport source (
        output valid, sequence_req, digest_w0, digest_w1, digest_w2, digest_w3,
        input  ready
    );
    modport sink (
        input  valid, sequence_req, digest_w0, digest_w1, digest_w2, digest_w3,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/arw_res_if.sv =====
// result item channel: verdict
`default_nettype none
interface arw_res_if
    import arw_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;

    modport source (
        output valid, verdict,
        input  ready
    );
    modport sink (
        input  valid, verdict,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/anti_replay_window_with_digest.sv =====
// top level of the anti-replay window with per-slot digest check
`default_nettype none
// Each packet item (sequence number plus 256-bit digest) gets one verdict:
// fresh, duplicate, too_old or conflict. In the load step the item is
// captured and the digest row of its slot is read from a 256-entry by
// 256-bit memory; in the evaluate step the window marks and highest sequence
// are updated, the digest is written back on a fresh verdict and the verdict
// goes to the output register. A new item is taken only after the previous
// one is evaluated; one item can be held while an earlier result waits.
// Reset clears the marks and the highest sequence at once; the digest memory
// needs no clearing since a slot's row is compared only once it is marked.
module anti_replay_window_with_digest
    import arw_pkg::*;
(
    input wire clk,
    input wire rst_n,
    arw_pkt_if.sink   pkt,
    arw_res_if.source result
);

    cmd_t cmd;

    arw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt.valid),
        .pkt_ready (pkt.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .cmd       (cmd)
    );

    arw_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sequence_req (pkt.sequence_req),
        .digest_w0    (pkt.digest_w0),
        .digest_w1    (pkt.digest_w1),
        .digest_w2    (pkt.digest_w2),
        .digest_w3    (pkt.digest_w3),
        .verdict      (result.verdict)
    );

`ifndef NO_ASSERTIONS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.ready) |=> !pkt.ready)
        else $error("second item accepted while one is in flight");

    a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |=> result.valid)
        else $error("evaluated item produced no result");

    a_eval_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval |-> (!result.valid || result.ready))
        else $error("result overwritten before it was taken");

    a_no_load_and_eval: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.load && cmd.eval))
        else $error("capture and evaluate in the same cycle");
`endif

endmodule
`default_nettype wire

// ===== rtl/arw_ctrl.sv =====
// controller: item sequencing and result valid
`default_nettype none
module arw_ctrl
    import arw_pkg::*;
(
    input  wire  clk,
    input  wire  rst_n,
    input  wire  pkt_valid,
    output logic pkt_ready,
    output logic res_valid,
    input  wire  res_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   ready_int;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        ready_int      = 1'b0;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                ready_int = 1'b1;
                if (pkt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                // wait for the output register to free up
                if (!res_valid_reg || res_ready)
                begin
                    cmd.eval       = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    assign pkt_ready = ready_int;
    assign res_valid = res_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/arw_dp.sv =====
// datapath: window marks, highest sequence, digest memory and verdict
`default_nettype none
module arw_dp
    import arw_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire cmd_t            cmd,
    input  wire [SEQ_W-1:0]      sequence_req,
    input  wire [DIGEST_W-1:0]   digest_w0,
    input  wire [DIGEST_W-1:0]   digest_w1,
    input  wire [DIGEST_W-1:0]   digest_w2,
    input  wire [DIGEST_W-1:0]   digest_w3,
    output logic [VERDICT_W-1:0] verdict
);

    logic [ROW_W-1:0]       digest_mem [WINDOW_SIZE];

    logic [SEQ_W-1:0]       seq_reg;
    logic [ROW_W-1:0]       digest_reg;
    logic [ROW_W-1:0]       rd_row_reg;
    logic [SEQ_W-1:0]       hi_reg;
    logic [SEQ_W-1:0]       hi_next;
    logic [WINDOW_SIZE-1:0] marks_reg;
    logic [WINDOW_SIZE-1:0] marks_next;
    verdict_t               verdict_reg;
    verdict_t               verdict_next;

    logic                   fwd;
    logic                   too_old;
    logic                   marked;
    logic                   same;
    logic                   wr_en;
    logic [SEQ_W-1:0]       back;
    logic [SEQ_W-1:0]       jump;
    logic [WIN_W-1:0]       offset;
    logic [WINDOW_SIZE-1:0] shifted;
    logic [WINDOW_SIZE-1:0] base;

    // item capture and digest row read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seq_reg    <= sequence_req;
            digest_reg <= {digest_w0, digest_w1, digest_w2, digest_w3};
            rd_row_reg <= digest_mem[sequence_req[WIN_W-1:0]];
        end
        if (wr_en)
        begin
            digest_mem[seq_reg[WIN_W-1:0]] <= digest_reg;
        end
    end

    always_comb
    begin
        fwd     = seq_reg > hi_reg;
        back    = hi_reg - seq_reg;
        jump    = seq_reg - hi_reg;
        too_old = (seq_reg == '0) || (!fwd && (back[SEQ_W-1:WIN_W] != '0));
        shifted = (jump[SEQ_W-1:WIN_W] != '0) ? '0 : (marks_reg << jump[WIN_W-1:0]);
        offset  = fwd ? '0 : back[WIN_W-1:0];
        marked  = !fwd && marks_reg[offset];
        same    = rd_row_reg == digest_reg;
        base    = fwd ? shifted : marks_reg;

        verdict_next = verdict_reg;
        hi_next      = hi_reg;
        marks_next   = marks_reg;
        wr_en        = 1'b0;
        if (cmd.eval)
        begin
            priority if (too_old)
            begin
                verdict_next = VERDICT_TOO_OLD;
            end
            else if (marked)
            begin
                verdict_next = same ? VERDICT_DUPLICATE : VERDICT_CONFLICT;
            end
            else
            begin
                verdict_next = VERDICT_FRESH;
                hi_next      = fwd ? seq_reg : hi_reg;
                marks_next   = base | (WINDOW_SIZE'(1) << offset);
                wr_en        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hi_reg      <= '0;
            marks_reg   <= '0;
            verdict_reg <= VERDICT_FRESH;
        end
        else
        begin
            hi_reg      <= hi_next;
            marks_reg   <= marks_next;
            verdict_reg <= verdict_next;
        end
    end

    assign verdict = verdict_reg;

endmodule
`default_nettype wire
